### rtl/core/swc_pkg.sv
// Shared types and constants for the set-associative write-back cache.
// No dependencies; used by swc_ctrl, swc_dp and the top level.
package swc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned SETS     = 64;
  localparam int unsigned WAYS     = 4;
  localparam int unsigned WPL      = 4;
  localparam int unsigned SET_W    = $clog2(SETS);
  localparam int unsigned WAY_W    = $clog2(WAYS);
  localparam int unsigned WSEL_W   = $clog2(WPL);
  localparam int unsigned TAG_W    = ADDR_W - 6 - SET_W;
  localparam int unsigned LINE_W   = ADDR_W - 6;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 168;

  // hit/miss counter slots
  localparam logic [1:0] CNT_RD_HIT  = 2'd0;
  localparam logic [1:0] CNT_RD_MISS = 2'd1;
  localparam logic [1:0] CNT_WR_HIT  = 2'd2;
  localparam logic [1:0] CNT_WR_MISS = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WPL-1:0]   line_t;

  // one memory row holds every way of a set
  typedef struct packed {
    line_t [WAYS-1:0]                 words;
    logic  [WAYS-1:0][TAG_W-1:0]      tags;
    logic  [WAYS-1:0][STAMP_W-1:0]    stamps;
  } set_row_t;

  typedef struct packed {
    logic              load;
    logic              lookup;
    logic              miss;
    logic              update;
    logic              clr_we;
    logic [LINE_W-1:0] clr_addr;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } sts_t;

endpackage

### rtl/core/set_assoc_writeback_cache.sv
// 4-way, 64-set write-back, write-allocate LRU cache over a 64K-word backing
// memory held inside the block. After reset the block clears the backing
// memory one line per cycle before it takes its first item. An item is taken
// in the idle state, then passes through the lookup and update states on a
// hit. A miss adds a miss state between them, in which the dirty victim line
// is written back and the new line is read, each a whole line wide on the
// backing memory's write and read ports. The update state waits while an
// earlier result is still stalled in the output register. One item is in
// work at a time, and the next may be accepted while the previous result
// waits in the output register.
// Depends on swc_pkg, swc_ctrl and swc_dp.
module set_assoc_writeback_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  // [19:0] address, [51:20] write_data, [55:52] zero
  input  logic [swc_pkg::IN_W-1:0]   s_tdata_i,
  // [0] action
  input  logic                       s_tuser_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  // [31:0] read_data, [32] hit, [33] wrote_back, [65:34] read_hits,
  // [97:66] read_misses, [129:98] write_hits, [161:130] write_misses
  output logic [swc_pkg::OUT_W-1:0]  m_tdata_o
);

  swc_pkg::ctl_t ctl;
  swc_pkg::sts_t sts;

  swc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  swc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

### rtl/core/swc_ctrl.sv
// Controller state machine of the cache: clearing pass, lookup, miss, update.
// Depends on swc_pkg; drives swc_dp through ctl_t and reads sts_t.
module swc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  swc_pkg::sts_t sts_i,
  output swc_pkg::ctl_t ctl_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [swc_pkg::LINE_W-1:0] clr_q, clr_d;
  logic                       fire;

  assign s_tready_o = (state_q == ST_IDLE);
  assign fire       = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    ctl_o   = '0;
    ctl_o.clr_addr = clr_q;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        ctl_o.load = fire;
        if (fire) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        ctl_o.lookup = 1'b1;
        state_d = sts_i.hit ? ST_UPDATE : ST_MISS;
      end
      ST_MISS: begin
        ctl_o.miss = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts_i.out_busy) begin
          ctl_o.update = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule

### rtl/core/swc_dp.sv
// Datapath of the cache: set memory, status bits, backing memory, counters,
// output register. Depends on swc_pkg; commanded by swc_ctrl.
module swc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swc_pkg::ctl_t               ctl_i,
  output swc_pkg::sts_t               sts_o,
  input  logic                        s_tuser_i,
  input  logic [swc_pkg::IN_W-1:0]    s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [swc_pkg::OUT_W-1:0]   m_tdata_o
);

  localparam int unsigned NSLOT = swc_pkg::SETS * swc_pkg::WAYS;

  swc_pkg::set_row_t set_mem [swc_pkg::SETS];
  swc_pkg::line_t    bk_mem  [2**swc_pkg::LINE_W];

  swc_pkg::set_row_t            row_q, row_d;
  swc_pkg::line_t               bk_rdata_q, line_c, line_new;
  logic                         act_q;
  logic [swc_pkg::ADDR_W-1:0]   addr_q;
  swc_pkg::word_t               wdata_q;
  logic [NSLOT-1:0]             valid_q, dirty_q;
  logic                         hit_q, wbneed_q;
  logic [swc_pkg::WAY_W-1:0]    way_q, hit_way_c, vic_c;
  logic                         hit_c;
  logic [swc_pkg::STAMP_W-1:0]  eff [swc_pkg::WAYS];
  logic [swc_pkg::STAMP_W-1:0]  clk_q, clk_nx;
  logic [swc_pkg::CNT_W-1:0]    cnt_q [4];
  logic [swc_pkg::CNT_W-1:0]    cnt_nx [4];
  logic [1:0]                   sel;
  logic                         out_vld_q;
  logic [swc_pkg::OUT_W-1:0]    out_q;
  swc_pkg::word_t               rdata_c;

  logic [swc_pkg::TAG_W-1:0]    tag;
  logic [swc_pkg::SET_W-1:0]    set;
  logic [swc_pkg::WSEL_W-1:0]   wsel;
  logic [swc_pkg::LINE_W-1:0]   line;
  logic [swc_pkg::SET_W-1:0]    s_set;

  assign tag   = addr_q[swc_pkg::ADDR_W-1 -: swc_pkg::TAG_W];
  assign set   = addr_q[6 +: swc_pkg::SET_W];
  assign wsel  = addr_q[4 +: swc_pkg::WSEL_W];
  assign line  = addr_q[swc_pkg::ADDR_W-1:6];
  assign s_set = s_tdata_i[6 +: swc_pkg::SET_W];

  // input item and set row
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      act_q   <= s_tuser_i;
      addr_q  <= s_tdata_i[swc_pkg::ADDR_W-1:0];
      wdata_q <= s_tdata_i[swc_pkg::ADDR_W +: swc_pkg::WORD_W];
      row_q   <= set_mem[s_set];
    end
    if (ctl_i.update) set_mem[set] <= row_d;
  end

  // tag match and LRU victim; invalid ways count as stamp zero
  always_comb begin
    hit_c     = 1'b0;
    hit_way_c = '0;
    vic_c     = '0;
    for (int i = 0; i < swc_pkg::WAYS; i++) begin
      eff[i] = valid_q[{set, swc_pkg::WAY_W'(i)}] ? row_q.stamps[i] : '0;
    end
    for (int i = swc_pkg::WAYS - 1; i >= 0; i--) begin
      if (valid_q[{set, swc_pkg::WAY_W'(i)}] && row_q.tags[i] == tag) begin
        hit_c     = 1'b1;
        hit_way_c = swc_pkg::WAY_W'(i);
      end
    end
    for (int i = 1; i < swc_pkg::WAYS; i++) begin
      if (eff[i] < eff[vic_c]) vic_c = swc_pkg::WAY_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.lookup) begin
      hit_q    <= hit_c;
      way_q    <= hit_c ? hit_way_c : vic_c;
      wbneed_q <= !hit_c && dirty_q[{set, vic_c}];
    end
  end

  // backing memory, one line per row
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_we) begin
      bk_mem[ctl_i.clr_addr] <= '0;
    end else if (ctl_i.miss && wbneed_q) begin
      bk_mem[{row_q.tags[way_q], set}] <= row_q.words[way_q];
    end
    if (ctl_i.miss) bk_rdata_q <= bk_mem[line];
  end

  // merge and counters
  always_comb begin
    line_c   = hit_q ? row_q.words[way_q] : bk_rdata_q;
    line_new = line_c;
    if (act_q) line_new[wsel] = wdata_q;
    clk_nx = (&clk_q) ? clk_q : clk_q + 1'b1;
    row_d = row_q;
    row_d.words[way_q]  = line_new;
    row_d.tags[way_q]   = tag;
    row_d.stamps[way_q] = clk_nx;
    rdata_c = act_q ? '0 : line_c[wsel];
    case ({act_q, hit_q})
      2'b01:   sel = swc_pkg::CNT_RD_HIT;
      2'b00:   sel = swc_pkg::CNT_RD_MISS;
      2'b11:   sel = swc_pkg::CNT_WR_HIT;
      default: sel = swc_pkg::CNT_WR_MISS;
    endcase
    for (int i = 0; i < 4; i++) cnt_nx[i] = cnt_q[i];
    if (!(&cnt_q[sel])) cnt_nx[sel] = cnt_q[sel] + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      dirty_q   <= '0;
      clk_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
    end else begin
      if (ctl_i.update) begin
        valid_q[{set, way_q}] <= 1'b1;
        dirty_q[{set, way_q}] <= hit_q ? (dirty_q[{set, way_q}] | act_q) : act_q;
        clk_q <= clk_nx;
        for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_nx[i];
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update) begin
      out_q <= {6'd0, cnt_nx[3], cnt_nx[2], cnt_nx[1], cnt_nx[0],
                wbneed_q, hit_q, rdata_c};
    end
  end

  assign m_tvalid_o     = out_vld_q;
  assign m_tdata_o      = out_q;
  assign sts_o.hit      = hit_c;
  assign sts_o.out_busy = out_vld_q && !m_tready_i;

endmodule

### rtl/core/swc_checker.sv
// Port-level checks for the cache top level, bound to it below.
// Depends on swc_pkg.
module swc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_tvalid_i,
  input logic                      s_tready_o,
  input logic                      m_tvalid_o,
  input logic                      m_tready_i,
  input logic [swc_pkg::OUT_W-1:0] m_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("second item taken while one is in work");

  a_wb_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(m_tdata_o[32] && m_tdata_o[33]))
    else $error("write-back reported on a hit");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> !s_tready_o || $past(!s_tready_o))
    else $error("result without an item");

endmodule

bind set_assoc_writeback_cache swc_checker u_swc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

### dv/set_assoc_writeback_cache_tb.sv
// Self-checking testbench for set_assoc_writeback_cache: random and directed
// reads and writes, checked against a cycle-free cache and memory predictor.
// Depends on swc_pkg and the set_assoc_writeback_cache RTL.
module set_assoc_writeback_cache_tb;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_MODIFIED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 100000;

  typedef struct packed {
    logic        action;
    logic [19:0] address;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0] write_misses;
    logic [31:0] write_hits;
    logic [31:0] read_misses;
    logic [31:0] read_hits;
    logic        wrote_back;
    logic        hit;
    logic [31:0] rdata;
  } reply_t;

  logic clk_i, rst_ni;
  logic s_tvalid_i, s_tready_o, s_tuser_i;
  logic [swc_pkg::IN_W-1:0] s_tdata_i;
  logic m_tvalid_o, m_tready_i;
  logic [swc_pkg::OUT_W-1:0] m_tdata_o;

  set_assoc_writeback_cache u_top (.*);

  // predictor state
  logic [31:0] mdl_words [swc_pkg::SETS*swc_pkg::WAYS*swc_pkg::WPL];
  logic [7:0]  mdl_tags  [swc_pkg::SETS*swc_pkg::WAYS];
  logic [1:0]  mdl_stat  [swc_pkg::SETS*swc_pkg::WAYS];
  logic [31:0] mdl_stamp [swc_pkg::SETS*swc_pkg::WAYS];
  logic [31:0] mdl_clock;
  logic [31:0] mdl_cnt [4];
  logic [31:0] mdl_mem [int];

  access_t pending_q[$];
  reply_t  expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  function automatic logic [31:0] mem_rd(input int idx);
    return mdl_mem.exists(idx) ? mdl_mem[idx] : 32'd0;
  endfunction

  function automatic reply_t cache_access(input access_t a);
    reply_t r;
    int set, tag, wsel, base, way, slot;
    r = '0;
    set  = a.address[11:6];
    tag  = a.address[19:12];
    wsel = a.address[5:4];
    base = set * swc_pkg::WAYS;
    way  = -1;
    if (mdl_clock != 32'hFFFF_FFFF) mdl_clock++;
    for (int i = 0; i < swc_pkg::WAYS; i++)
      if (way < 0 && mdl_tags[base+i] == tag &&
          (mdl_stat[base+i] == ST_VALID || mdl_stat[base+i] == ST_MODIFIED))
        way = i;
    r.hit = (way >= 0);
    if (!r.hit) begin
      way = 0;
      for (int i = 1; i < swc_pkg::WAYS; i++)
        if (mdl_stamp[base+i] < mdl_stamp[base+way]) way = i;
      slot = base + way;
      if (mdl_stat[slot] == ST_MODIFIED) begin
        for (int w = 0; w < swc_pkg::WPL; w++)
          mdl_mem[(mdl_tags[slot]*swc_pkg::SETS + set)*swc_pkg::WPL + w] =
            mdl_words[slot*swc_pkg::WPL + w];
        r.wrote_back = 1'b1;
      end
      mdl_tags[slot] = tag;
      for (int w = 0; w < swc_pkg::WPL; w++)
        mdl_words[slot*swc_pkg::WPL + w] =
          mem_rd((tag*swc_pkg::SETS + set)*swc_pkg::WPL + w);
      mdl_stat[slot] = ST_VALID;
    end
    slot = base + way;
    mdl_stamp[slot] = mdl_clock;
    if (a.action == ACT_WRITE) begin
      mdl_words[slot*swc_pkg::WPL + wsel] = a.wdata;
      mdl_stat[slot] = ST_MODIFIED;
      if (r.hit) begin
        if (mdl_cnt[swc_pkg::CNT_WR_HIT] != '1) mdl_cnt[swc_pkg::CNT_WR_HIT]++;
      end else if (mdl_cnt[swc_pkg::CNT_WR_MISS] != '1) mdl_cnt[swc_pkg::CNT_WR_MISS]++;
    end else begin
      r.rdata = mdl_words[slot*swc_pkg::WPL + wsel];
      if (r.hit) begin
        if (mdl_cnt[swc_pkg::CNT_RD_HIT] != '1) mdl_cnt[swc_pkg::CNT_RD_HIT]++;
      end else if (mdl_cnt[swc_pkg::CNT_RD_MISS] != '1) mdl_cnt[swc_pkg::CNT_RD_MISS]++;
    end
    r.read_hits    = mdl_cnt[swc_pkg::CNT_RD_HIT];
    r.read_misses  = mdl_cnt[swc_pkg::CNT_RD_MISS];
    r.write_hits   = mdl_cnt[swc_pkg::CNT_WR_HIT];
    r.write_misses = mdl_cnt[swc_pkg::CNT_WR_MISS];
    return r;
  endfunction

  function automatic void add(input logic act, input logic [19:0] adr, input logic [31:0] d);
    access_t a;
    a.action = act; a.address = adr; a.wdata = d;
    pending_q.push_back(a);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    logic [19:0] adr;
    int hot_tag;
    mdl_clock = '0;
    for (int i = 0; i < swc_pkg::SETS*swc_pkg::WAYS*swc_pkg::WPL; i++) mdl_words[i] = '0;
    for (int i = 0; i < swc_pkg::SETS*swc_pkg::WAYS; i++) begin
      mdl_tags[i] = '0; mdl_stat[i] = ST_INVALID; mdl_stamp[i] = '0;
    end
    for (int i = 0; i < 4; i++) mdl_cnt[i] = '0;
    // directed: cold read, extremes, fill a set past its ways to force dirty evictions
    add(ACT_READ, 20'h00000, 32'h0);
    add(ACT_WRITE, 20'h00000, 32'h8000_0000);
    add(ACT_WRITE, 20'hFFFFF, 32'h7FFF_FFFF);
    add(ACT_READ, 20'hFFFFF, 32'h0);
    add(ACT_READ, 20'hFFFF0, 32'h0);
    add(ACT_WRITE, 20'h0000F, 32'hFFFF_FFFF);
    add(ACT_READ, 20'h00000, 32'h0);
    for (int t = 1; t <= 6; t++) add(ACT_WRITE, {8'(t), 6'd5, 2'(t), 4'hA}, 32'hA5A5_0000 + t);
    for (int t = 1; t <= 6; t++) add(ACT_READ, {8'(t), 6'd5, 2'(t), 4'h0}, 32'h0);
    add(ACT_READ, 20'h00000, 32'h0);
    add(ACT_READ, 20'hFFFFF, 32'h0);
    // random: mostly a few hot tags so sets thrash and lines come back dirty
    for (int n = 0; n < 2000; n++) begin
      adr = 20'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        hot_tag = $urandom_range(0, 7);
        adr[19:12] = (hot_tag == 7) ? 8'hFF : 8'(hot_tag);
        if ($urandom_range(0, 1)) adr[11:6] = 6'($urandom_range(0, 3));
      end
      add(1'($urandom), adr, $urandom);
    end
  end

  // reset and driver
  initial begin
    rst_ni = 1'b0; s_tvalid_i = 1'b0; s_tdata_i = '0; s_tuser_i = 1'b0; m_tready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        expected_q.push_back(cache_access(pending_q.pop_front()));
      end
      if ((!s_tvalid_i || s_tready_o)) begin
        if (pending_q.size() > ((s_tvalid_i && s_tready_o) ? 0 : 0) && burst_left > 0
            && !(s_tvalid_i && s_tready_o && pending_q.size() == 0)) begin
          s_tvalid_i <= 1'b1;
          s_tuser_i  <= pending_q[0].action;
          s_tdata_i  <= {4'd0, pending_q[0].wdata, pending_q[0].address};
          burst_left <= burst_left - 1;
        end else begin
          s_tvalid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
          else begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      m_tready_i <= (stall_phase < 8) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    reply_t got, exp;
    if (rst_ni) begin
      if ((m_tvalid_o && m_tready_i) || (s_tvalid_i && s_tready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid_o && m_tready_i) begin
        got = m_tdata_o[161:0];
        if (expected_q.size() == 0) begin
          report("unexpected result item", got.rdata, 32'd0);
        end else begin
          exp = expected_q.pop_front();
          if (got.rdata !== exp.rdata) report("read_data", got.rdata, exp.rdata);
          if (got.hit !== exp.hit) report("hit", got.hit, exp.hit);
          if (got.wrote_back !== exp.wrote_back)
            report("wrote_back", got.wrote_back, exp.wrote_back);
          if (got.read_hits !== exp.read_hits)
            report("read_hits", got.read_hits, exp.read_hits);
          if (got.read_misses !== exp.read_misses)
            report("read_misses", got.read_misses, exp.read_misses);
          if (got.write_hits !== exp.write_hits)
            report("write_hits", got.write_hits, exp.write_hits);
          if (got.write_misses !== exp.write_misses)
            report("write_misses", got.write_misses, exp.write_misses);
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL set_assoc_writeback_cache");
        $finish;
      end
      if (pending_q.size() == 0 && !s_tvalid_i && expected_q.size() == 0) begin
        repeat (20) @(posedge clk_i);
        if (errors == 0 && !m_tvalid_o) begin
          $display("PASS set_assoc_writeback_cache");
        end else begin
          $display("FAIL set_assoc_writeback_cache");
        end
        $finish;
      end
    end
  end

endmodule

### files.f
rtl/core/swc_pkg.sv
rtl/core/swc_ctrl.sv
rtl/core/swc_dp.sv
rtl/core/set_assoc_writeback_cache.sv
rtl/core/swc_checker.sv
dv/set_assoc_writeback_cache_tb.sv
